FILE: sv/scalar_kalman_angle_filter_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scalar Kalman angle filter core
// Shared property forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SCALAR_KALMAN_ANGLE_FILTER_CORE_DEFINES_SVH
`define SCALAR_KALMAN_ANGLE_FILTER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKAF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SKAF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/skaf_pkg.sv
// ----------------------------------------------------------------------------
// Scalar Kalman angle filter package
// Widths, register indexes, shared types and saturation helpers.
// ----------------------------------------------------------------------------
package skaf_pkg;

	localparam int NUM_CHANNELS_DEF = 3;
	localparam int CH_W      = 2;
	localparam int DATA_W    = 32;
	localparam int VAR_W     = 31;
	localparam int GAIN_W    = 17;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_W     = 48;
	localparam int DEN_W     = 33;

	localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROCESS_STD      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MEAS_STD_TILT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MEAS_STD_HEADING = 3'd3;

	localparam logic [CFG_W-1:0]  CFG_RESET  = 16'd256;
	localparam logic [GAIN_W-1:0] GAIN_ONE   = 17'd65536;
	localparam logic [VAR_W-1:0]  VAR_MAX    = 31'h7FFF_FFFF;
	localparam logic [CH_W-1:0]   HEADING_CH = 2'd2;

	typedef struct packed {
		logic [CFG_W-1:0] step_time;
		logic [CFG_W-1:0] process_std;
		logic [CFG_W-1:0] meas_std_tilt;
		logic [CFG_W-1:0] meas_std_heading;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic mult1;
		logic pred_ang;
		logic pred_var;
		logic div_start;
		logic mult2;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic chan_ok;
		logic div_busy;
	} stat_t;

	function automatic logic [DATA_W-1:0] sat_angle(input logic signed [51:0] v);
		logic [DATA_W-1:0] r;
		if (v > 52'sd2147483647) begin
			r = 32'h7FFF_FFFF;
		end else if (v < -52'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [VAR_W-1:0] sat_var(input logic [48:0] v);
		logic [VAR_W-1:0] r;
		if (v > 49'(VAR_MAX)) begin
			r = VAR_MAX;
		end else begin
			r = v[VAR_W-1:0];
		end
		return r;
	endfunction

endpackage

FILE: sv/skaf_div.sv
// ----------------------------------------------------------------------------
// Restoring divider
// Produces one quotient bit per cycle; the quotient must fit in Q_W bits.
// ----------------------------------------------------------------------------
module skaf_div import skaf_pkg::*; #(
	parameter int NUM_BITS = NUM_W,
	parameter int DEN_BITS = DEN_W,
	parameter int Q_W      = GAIN_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_BITS-1:0] num,
	input  logic [DEN_BITS-1:0] den,
	output logic                busy,
	output logic [Q_W-1:0]      quot
);

	localparam int CNT_W = $clog2(Q_W + 1);

	logic [DEN_BITS-1:0] rem_q;
	logic [DEN_BITS-1:0] den_q;
	logic [Q_W-1:0]      num_q;
	logic [Q_W-1:0]      quot_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic [DEN_BITS:0]   trial;
	logic                take;

	assign trial = {rem_q, num_q[Q_W-1]};
	assign take  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(Q_W);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			busy_q <= (cnt_q != CNT_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= DEN_BITS'(num >> Q_W);
			num_q  <= num[Q_W-1:0];
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			if (take) begin
				rem_q <= DEN_BITS'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[DEN_BITS-1:0];
			end
			num_q  <= {num_q[Q_W-2:0], 1'b0};
			quot_q <= {quot_q[Q_W-2:0], take};
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;

endmodule

FILE: sv/skaf_datapath.sv
// ----------------------------------------------------------------------------
// Kalman filter datapath
// Per-channel angle and variance stores, multipliers, divider and result
// registers, stepped by commands from the controller.
// ----------------------------------------------------------------------------
module skaf_datapath import skaf_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  cmd_t                     cmd,
	output stat_t                    stat,
	input  logic [CH_W-1:0]          channel,
	input  logic signed [DATA_W-1:0] rate,
	input  logic signed [DATA_W-1:0] measured_angle,
	output logic [CH_W-1:0]          out_channel,
	output logic signed [DATA_W-1:0] filtered_angle,
	output logic [VAR_W-1:0]         uncertainty,
	output logic [GAIN_W-1:0]        gain
);

	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic signed [DATA_W-1:0] angle_store_q [NUM_CHANNELS];
	logic [VAR_W-1:0]         variance_store_q [NUM_CHANNELS];

	logic [CH_W-1:0]          ch_q;
	logic signed [DATA_W-1:0] rate_q;
	logic signed [DATA_W-1:0] meas_q;
	logic signed [DATA_W-1:0] ang_q;
	logic [VAR_W-1:0]         var_q;
	logic signed [48:0]       prod_rate_q;
	logic [31:0]              tq_q;
	logic [31:0]              rr_q;
	logic [63:0]              tq2_q;
	logic                     den_zero_q;
	logic [GAIN_W-1:0]        k_q;
	logic signed [50:0]       prod_corr_q;
	logic [47:0]              prod_var_q;

	logic [CH_W-1:0]          out_ch_q;
	logic signed [DATA_W-1:0] out_ang_q;
	logic [VAR_W-1:0]         out_var_q;
	logic [GAIN_W-1:0]        out_gain_q;

	logic [IDX_W-1:0]         idx;
	logic                     chan_ok;
	logic [CFG_W-1:0]         r_sel;
	logic signed [48:0]       rnd_rate;
	logic [64:0]              qq_full;
	logic [VAR_W-1:0]         qq_sat;
	logic [31:0]              var_sum;
	logic [DEN_W-1:0]         den;
	logic [NUM_W-1:0]         num;
	logic                     div_busy;
	logic [GAIN_W-1:0]        quot;
	logic [GAIN_W-1:0]        k;
	logic signed [DATA_W:0]   diff;
	logic signed [50:0]       rnd_corr;
	logic signed [DATA_W-1:0] ang_new;
	logic [48:0]              var_rnd;
	logic [VAR_W-1:0]         var_new;

	assign idx     = IDX_W'(ch_q);
	assign chan_ok = int'(ch_q) < NUM_CHANNELS;
	assign r_sel   = (ch_q == HEADING_CH) ? cfg.meas_std_heading : cfg.meas_std_tilt;

	assign rnd_rate = (prod_rate_q + 49'sd128) >>> 8;
	assign qq_full  = (65'(tq2_q) + 65'h8000) >> 16;
	assign qq_sat   = (qq_full > 65'(VAR_MAX)) ? VAR_MAX : qq_full[VAR_W-1:0];
	assign var_sum  = 32'(var_q) + 32'(qq_sat);

	assign den = DEN_W'(var_q) + DEN_W'(rr_q);
	assign num = {1'b0, var_q, 16'b0} + NUM_W'(den >> 1);

	assign k    = den_zero_q ? '0 : ((quot > GAIN_ONE) ? GAIN_ONE : quot);
	assign diff = (DATA_W+1)'(meas_q) - (DATA_W+1)'(ang_q);

	assign rnd_corr = (prod_corr_q + 51'sd32768) >>> 16;
	assign ang_new  = sat_angle(52'(ang_q) + 52'(rnd_corr));
	assign var_rnd  = (49'(prod_var_q) + 49'h8000) >> 16;
	assign var_new  = sat_var(var_rnd);

	skaf_div #(
		.NUM_BITS(NUM_W),
		.DEN_BITS(DEN_W),
		.Q_W     (GAIN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (num),
		.den   (den),
		.busy  (div_busy),
		.quot  (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				angle_store_q[i]    <= '0;
				variance_store_q[i] <= '0;
			end
		end else if (cmd.finish && chan_ok) begin
			angle_store_q[idx]    <= ang_new;
			variance_store_q[idx] <= var_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ch_q   <= channel;
			rate_q <= rate;
			meas_q <= measured_angle;
		end
		if (cmd.mult1) begin
			prod_rate_q <= 49'($signed({1'b0, cfg.step_time})) * 49'(rate_q);
			tq_q        <= 32'(cfg.step_time) * 32'(cfg.process_std);
			rr_q        <= 32'(r_sel) * 32'(r_sel);
			if (chan_ok) begin
				ang_q <= angle_store_q[idx];
				var_q <= variance_store_q[idx];
			end
		end
		if (cmd.pred_ang) begin
			ang_q <= sat_angle(52'(ang_q) + 52'(rnd_rate));
			tq2_q <= 64'(tq_q) * 64'(tq_q);
		end
		if (cmd.pred_var) begin
			var_q <= var_sum[31] ? VAR_MAX : var_sum[VAR_W-1:0];
		end
		if (cmd.div_start) begin
			den_zero_q <= (den == '0);
		end
		if (cmd.mult2) begin
			k_q         <= k;
			prod_corr_q <= 51'($signed({1'b0, k})) * 51'(diff);
			prod_var_q  <= 48'(GAIN_ONE - k) * 48'(var_q);
		end
		if (cmd.finish) begin
			out_ch_q <= ch_q;
			if (chan_ok) begin
				out_ang_q  <= ang_new;
				out_var_q  <= var_new;
				out_gain_q <= k_q;
			end else begin
				out_ang_q  <= '0;
				out_var_q  <= '0;
				out_gain_q <= '0;
			end
		end
	end

	assign stat.chan_ok  = chan_ok;
	assign stat.div_busy = div_busy;

	assign out_channel    = out_ch_q;
	assign filtered_angle = out_ang_q;
	assign uncertainty    = out_var_q;
	assign gain           = out_gain_q;

endmodule

FILE: sv/skaf_ctrl.sv
// ----------------------------------------------------------------------------
// Kalman filter controller
// Sequences one update through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
module skaf_ctrl import skaf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_M1   = 3'd1;
	localparam logic [2:0] S_M2   = 3'd2;
	localparam logic [2:0] S_M3   = 3'd3;
	localparam logic [2:0] S_M4   = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_M5   = 3'd6;
	localparam logic [2:0] S_FIN  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_M1;
				end
			end
			S_M1: begin
				state_d = stat.chan_ok ? S_M2 : S_FIN;
			end
			S_M2:  state_d = S_M3;
			S_M3:  state_d = S_M4;
			S_M4:  state_d = S_DIV;
			S_DIV: begin
				if (!stat.div_busy) begin
					state_d = S_M5;
				end
			end
			S_M5:  state_d = S_FIN;
			S_FIN: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.load      = (state_q == S_IDLE) && in_valid;
		cmd.mult1     = (state_q == S_M1);
		cmd.pred_ang  = (state_q == S_M2);
		cmd.pred_var  = (state_q == S_M3);
		cmd.div_start = (state_q == S_M4);
		cmd.mult2     = (state_q == S_M5);
		cmd.finish    = (state_q == S_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

FILE: sv/scalar_kalman_angle_filter_core.sv
// ----------------------------------------------------------------------------
// Scalar Kalman angle filter core
// Three-axis (by default) one-dimensional Kalman filter in fixed point.
// ----------------------------------------------------------------------------
// Each input beat carries a channel, an angular rate and a measured angle.
// The core predicts the stored angle and variance of that channel, forms the
// gain, corrects both and returns one result beat with the new angle, the
// new variance and the gain used. A channel beyond the configured count
// leaves all state unchanged and returns a result beat of zeros.
// The configuration channel writes the four noise and timing registers; it
// is always ready, and writes to unknown indexes are dropped. Registers are
// only to be written while the core is idle.
// The core works on one item at a time: the next input is taken only once
// the previous item has finished. The gain is formed in a bit-serial divider.
// The result sits in an output register, so a stalled receiver holds only
// the final step: the core finishes its work and waits with the next result
// until the previous one has been taken.
// Reset restores the default registers (Ts = 1.0, all deviations 1.0) and
// clears every channel's angle and variance to zero.
// ----------------------------------------------------------------------------
`include "scalar_kalman_angle_filter_core_defines.svh"

module scalar_kalman_angle_filter_core import skaf_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [CH_W-1:0]          channel,
	input  logic signed [DATA_W-1:0] rate,
	input  logic signed [DATA_W-1:0] measured_angle,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [CH_W-1:0]          out_channel,
	output logic signed [DATA_W-1:0] filtered_angle,
	output logic [VAR_W-1:0]         uncertainty,
	output logic [GAIN_W-1:0]        gain,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data
);

	cfg_t  cfg_q;
	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_time        <= CFG_RESET;
			cfg_q.process_std      <= CFG_RESET;
			cfg_q.meas_std_tilt    <= CFG_RESET;
			cfg_q.meas_std_heading <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_STEP_TIME:        cfg_q.step_time        <= cfg_data;
				REG_PROCESS_STD:      cfg_q.process_std      <= cfg_data;
				REG_MEAS_STD_TILT:    cfg_q.meas_std_tilt    <= cfg_data;
				REG_MEAS_STD_HEADING: cfg_q.meas_std_heading <= cfg_data;
				default: ;
			endcase
		end
	end

	skaf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	skaf_datapath #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.cmd           (cmd),
		.stat          (stat),
		.channel       (channel),
		.rate          (rate),
		.measured_angle(measured_angle),
		.out_channel   (out_channel),
		.filtered_angle(filtered_angle),
		.uncertainty   (uncertainty),
		.gain          (gain)
	);

	`SKAF_ASSERT_NEXT(a_one_item_in_flight, in_valid && in_ready, !in_ready, "input taken while busy")
	`SKAF_ASSERT_SAME(a_gain_range, out_valid, gain <= GAIN_ONE, "gain above one")
	`SKAF_ASSERT_SAME(a_bad_channel_zero, out_valid && (int'(out_channel) >= NUM_CHANNELS), (filtered_angle == '0) && (uncertainty == '0) && (gain == '0), "unknown channel result not zero")

endmodule

FILE: tb/sv/scalar_kalman_angle_filter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scalar Kalman angle filter core testbench
// Drives angle samples and register writes through the valid/ready channels.
// A scoreboard class keeps its own fixed-point copy of every channel's angle
// and variance. It predicts each estimate and checks the result beats in
// order. Both sides idle at random, and the receiver holds off once for a
// long stretch so that the core stalls in its final step.
// ----------------------------------------------------------------------------
module scalar_kalman_angle_filter_core_tb;
	import skaf_pkg::*;

	typedef longint          s64_t;
	typedef longint unsigned u64_t;

	typedef struct {
		logic [CH_W-1:0]          chan;
		logic signed [DATA_W-1:0] angle;
		logic [VAR_W-1:0]         variance;
		logic [GAIN_W-1:0]        k;
	} estimate_t;

	localparam int   NUM_CH       = NUM_CHANNELS_DEF;
	localparam int   RESET_CYCLES = 7;
	localparam int   HOLD_CYCLES  = 400;
	localparam int   DRAIN_CYCLES = 40;
	localparam int   CYCLE_LIMIT  = 1000000;
	localparam int   RAND_PHASES  = 10;
	localparam int   PHASE_ITEMS  = 100;
	localparam s64_t ANG_HI       = 64'sd2147483647;
	localparam s64_t ANG_LO       = -64'sd2147483648;
	localparam s64_t VAR_LIMIT    = s64_t'(VAR_MAX);

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam logic [CH_W-1:0]      ROLL_CH      = 2'd0;
	localparam logic [CH_W-1:0]      PITCH_CH     = 2'd1;
	localparam logic [CH_W-1:0]      SPARE_CH     = 2'd3;

	localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

	class kalman_scoreboard;
		estimate_t        pending_estimates[$];
		logic [CFG_W-1:0] step_time;
		logic [CFG_W-1:0] process_std;
		logic [CFG_W-1:0] meas_std_tilt;
		logic [CFG_W-1:0] meas_std_heading;
		s64_t             angle_q[NUM_CH];
		s64_t             var_q[NUM_CH];
		int               errors;

		function new();
			step_time        = CFG_RESET;
			process_std      = CFG_RESET;
			meas_std_tilt    = CFG_RESET;
			meas_std_heading = CFG_RESET;
			foreach (angle_q[i]) begin
				angle_q[i] = 0;
				var_q[i]   = 0;
			end
			errors = 0;
		endfunction

		function s64_t round_shift(s64_t x, int k);
			return (x + (s64_t'(1) <<< (k - 1))) >>> k;
		endfunction

		function s64_t clamp_angle(s64_t v);
			if (v > ANG_HI) begin
				return ANG_HI;
			end
			if (v < ANG_LO) begin
				return ANG_LO;
			end
			return v;
		endfunction

		function s64_t clamp_var(s64_t v);
			return (v > VAR_LIMIT) ? VAR_LIMIT : v;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_STEP_TIME: begin
					step_time = data;
				end
				REG_PROCESS_STD: begin
					process_std = data;
				end
				REG_MEAS_STD_TILT: begin
					meas_std_tilt = data;
				end
				REG_MEAS_STD_HEADING: begin
					meas_std_heading = data;
				end
				default: begin
				end
			endcase
		endfunction

		function void note_sample(logic [CH_W-1:0] ch, logic signed [DATA_W-1:0] rt,
				logic signed [DATA_W-1:0] meas);
			estimate_t e;
			s64_t      ang;
			s64_t      p;
			u64_t      tq;
			u64_t      qq;
			u64_t      r;
			u64_t      denom;
			u64_t      k;
			e.chan     = ch;
			e.angle    = '0;
			e.variance = '0;
			e.k        = '0;
			if (ch < NUM_CH) begin
				ang = clamp_angle(angle_q[ch]
					+ round_shift(s64_t'(step_time) * s64_t'(rt), 8));
				tq = u64_t'(step_time) * u64_t'(process_std);
				qq = (tq * tq + 64'h8000) >> 16;
				p  = clamp_var(var_q[ch] + clamp_var(s64_t'(qq)));
				if (qq > u64_t'(VAR_LIMIT)) begin
					p = VAR_LIMIT;
				end
				r     = (ch == HEADING_CH) ? u64_t'(meas_std_heading) : u64_t'(meas_std_tilt);
				denom = u64_t'(p) + r * r;
				if (denom == 0) begin
					k = 0;
				end else begin
					k = ((u64_t'(p) << 16) + (denom >> 1)) / denom;
				end
				if (k > u64_t'(GAIN_ONE)) begin
					k = u64_t'(GAIN_ONE);
				end
				ang = clamp_angle(ang + round_shift(s64_t'(k) * (s64_t'(meas) - ang), 16));
				p   = clamp_var(s64_t'(((u64_t'(GAIN_ONE) - k) * u64_t'(p) + 64'h8000) >> 16));
				angle_q[ch] = ang;
				var_q[ch]   = p;
				e.angle     = ang[DATA_W-1:0];
				e.variance  = p[VAR_W-1:0];
				e.k         = k[GAIN_W-1:0];
			end
			pending_estimates.push_back(e);
		endfunction

		function void check_result(logic [CH_W-1:0] ch, logic signed [DATA_W-1:0] ang,
				logic [VAR_W-1:0] unc, logic [GAIN_W-1:0] k);
			estimate_t e;
			if (pending_estimates.size() == 0) begin
				$error("Result beat on channel %0d with no estimate waiting", ch);
				errors++;
				return;
			end
			e = pending_estimates.pop_front();
			if (ch !== e.chan) begin
				$error("out_channel: expected %0d, actual %0d", e.chan, ch);
				errors++;
			end
			if (ang !== e.angle) begin
				$error("filtered_angle: expected %0d, actual %0d", e.angle, ang);
				errors++;
			end
			if (unc !== e.variance) begin
				$error("uncertainty: expected %0d, actual %0d", e.variance, unc);
				errors++;
			end
			if (k !== e.k) begin
				$error("gain: expected %0d, actual %0d", e.k, k);
				errors++;
			end
		endfunction

		function void report_leftover();
			if (pending_estimates.size() != 0) begin
				$error("%0d estimates never arrived", pending_estimates.size());
				errors += pending_estimates.size();
			end
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n         = 1'b0;
	logic                     in_valid       = 1'b0;
	logic                     in_ready;
	logic [CH_W-1:0]          channel        = '0;
	logic signed [DATA_W-1:0] rate           = '0;
	logic signed [DATA_W-1:0] measured_angle = '0;
	logic                     out_valid;
	logic                     out_ready      = 1'b0;
	logic [CH_W-1:0]          out_channel;
	logic signed [DATA_W-1:0] filtered_angle;
	logic [VAR_W-1:0]         uncertainty;
	logic [GAIN_W-1:0]        gain;
	logic                     cfg_valid      = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index      = '0;
	logic [CFG_W-1:0]         cfg_data       = '0;

	kalman_scoreboard board;
	int               samples_sent  = 0;
	int               results_seen  = 0;
	int               settings_used = 0;
	bit               held_off      = 1'b0;

	scalar_kalman_angle_filter_core #(
		.NUM_CHANNELS(NUM_CH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.channel(channel),
		.rate(rate),
		.measured_angle(measured_angle),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_channel(out_channel),
		.filtered_angle(filtered_angle),
		.uncertainty(uncertainty),
		.gain(gain),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int gap_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			return 0;
		end
		if (pick < 95) begin
			return $urandom_range(1, 4);
		end
		return $urandom_range(15, 60);
	endfunction

	function automatic logic [CFG_W-1:0] pick_setting();
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0: return '0;
			1: return '1;
			2: return CFG_RESET;
			3, 4, 5, 6: return CFG_W'($urandom_range(1, 1024));
			default: return CFG_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_q16(int span);
		if ($urandom_range(0, 9) < 7) begin
			return DATA_W'(int'($urandom_range(0, 2 * span)) - span);
		end
		return DATA_W'($urandom());
	endfunction

	task automatic send_sample(logic [CH_W-1:0] ch, logic signed [DATA_W-1:0] rt,
			logic signed [DATA_W-1:0] meas, int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		channel        <= ch;
		rate           <= rt;
		measured_angle <= meas;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_sample(channel, rate, measured_angle);
		samples_sent++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.write_reg(cfg_index, cfg_data);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (board.pending_estimates.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_settings(logic [CFG_W-1:0] st, logic [CFG_W-1:0] ps,
			logic [CFG_W-1:0] tilt, logic [CFG_W-1:0] heading);
		settle();
		write_reg(REG_STEP_TIME, st);
		write_reg(REG_PROCESS_STD, ps);
		write_reg(REG_SPARE_LO, CFG_W'($urandom()));
		write_reg(REG_MEAS_STD_TILT, tilt);
		write_reg(REG_MEAS_STD_HEADING, heading);
		write_reg(REG_SPARE_HI, CFG_W'($urandom()));
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			board.check_result(out_channel, filtered_angle, uncertainty, gain);
			results_seen++;
		end
	end

	initial begin : result_sink
		forever begin
			if (!held_off && results_seen >= 150 && in_valid) begin
				held_off = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if ($urandom_range(0, 3) != 0) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end else begin
				out_ready <= 1'b0;
				repeat (1 + gap_len()) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("scalar_kalman_angle_filter_core_tb failed");
		$finish;
	end

	initial begin : stimulus
		int  n;
		int  ph;
		bit  quiet;
		logic [CH_W-1:0] ch;
		board = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_sample(ROLL_CH, '0, '0, gap_len());
		send_sample(PITCH_CH, Q_MAX, Q_MAX, gap_len());
		send_sample(HEADING_CH, Q_MIN, Q_MIN, gap_len());
		send_sample(SPARE_CH, DATA_W'($urandom()), DATA_W'($urandom()), gap_len());
		send_sample(ROLL_CH, Q_MIN, Q_MAX, gap_len());
		send_sample(PITCH_CH, Q_MAX, Q_MIN, gap_len());

		apply_settings('1, '1, '1, '0);
		send_sample(ROLL_CH, Q_MAX, Q_MIN, gap_len());
		send_sample(PITCH_CH, Q_MIN, Q_MAX, gap_len());
		send_sample(HEADING_CH, DATA_W'($urandom()), DATA_W'($urandom()), gap_len());
		send_sample(HEADING_CH, '0, '0, gap_len());
		send_sample(SPARE_CH, Q_MAX, Q_MAX, gap_len());

		// With every deviation at zero the gain reaches one, the variance collapses
		// to zero and the following update meets a zero denominator.
		apply_settings('0, '0, '0, '0);
		send_sample(ROLL_CH, '0, Q_MAX, gap_len());
		send_sample(ROLL_CH, '0, Q_MIN, gap_len());
		send_sample(HEADING_CH, Q_MAX, '0, gap_len());
		send_sample(HEADING_CH, Q_MIN, Q_MAX, gap_len());
		send_sample(PITCH_CH, DATA_W'($urandom()), DATA_W'($urandom()), gap_len());
		send_sample(PITCH_CH, DATA_W'($urandom()), DATA_W'($urandom()), gap_len());

		for (ph = 0; ph < RAND_PHASES; ph++) begin
			apply_settings(pick_setting(), pick_setting(), pick_setting(), pick_setting());
			quiet = ($urandom_range(0, 3) == 0);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				ch = ($urandom_range(0, 9) == 0) ? SPARE_CH : CH_W'($urandom_range(0, 2));
				send_sample(ch, pick_q16(1 << 20), pick_q16(1 << 24), quiet ? 0 : gap_len());
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		board.report_leftover();
		$display("Sent %0d samples and checked %0d estimates under %0d register settings.",
			samples_sent, results_seen, settings_used + 1);
		$display("Included saturation, zero gain, the unused channel and a %0d-cycle output stall.",
			HOLD_CYCLES);
		if (board.errors == 0) begin
			$display("scalar_kalman_angle_filter_core_tb passed");
		end else begin
			$display("scalar_kalman_angle_filter_core_tb failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/skaf_pkg.sv
sv/skaf_div.sv
sv/skaf_datapath.sv
sv/skaf_ctrl.sv
sv/scalar_kalman_angle_filter_core.sv
tb/sv/scalar_kalman_angle_filter_core_tb.sv
